// ----- hdl/qoi_enc_pkg.sv -----
// ---------------------------------------------------------------------------
// QOI encoder package
// Shared types, byte codes and the colour hash used by the encoder modules.
// ---------------------------------------------------------------------------
package qoi_enc_pkg;

   // Default for the longest run that one run byte may carry.
   localparam int MAX_RUN_DEFAULT = 62;

   // Colour table geometry and stored colour width.
   localparam int TABLE_DEPTH = 64;
   localparam int HASH_W      = 6;
   localparam int COLOUR_W    = 24;

   // The pending run count always fits in six bits.
   localparam int RUN_W = 6;

   // Byte counter inside one segment of output bytes (header is longest).
   localparam int IDX_W = 4;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Stream constants.
   localparam logic [31:0] HDR_MAGIC       = 32'h716F_6966;
   localparam logic [7:0]  HDR_CHANNELS    = 8'h03;
   localparam logic [7:0]  HDR_COLOURSPACE = 8'h01;
   localparam logic [7:0]  OP_RGB          = 8'hFE;
   localparam logic [1:0]  OP_DIFF_TAG     = 2'b01;
   localparam logic [1:0]  OP_LUMA_TAG     = 2'b10;
   localparam logic [1:0]  OP_RUN_TAG      = 2'b11;
   localparam logic [7:0]  END_PAD         = 8'h00;
   localparam logic [7:0]  END_LAST        = 8'h01;

   // Segment lengths in bytes.
   localparam logic [IDX_W-1:0] HDR_LEN = 4'd14;
   localparam logic [IDX_W-1:0] RUN_LEN = 4'd1;
   localparam logic [IDX_W-1:0] END_LEN = 4'd8;

   // Everything a pixel emits, in stream order: header, run, op, end marker.
   typedef struct packed {
      logic            has_hdr;
      logic            has_run;
      logic [7:0]      run_byte;
      logic [2:0]      op_len;
      logic [3:0][7:0] op_bytes;
      logic            has_end;
   } desc_type;

   // Output segment being sent; SEG_IDLE also marks the start of a list.
   typedef enum logic [2:0] {
      SEG_IDLE,
      SEG_HDR,
      SEG_RUN,
      SEG_OP,
      SEG_END
   } seg_type;

   // Colour table index: (3r + 5g + 7b) mod 64.
   function automatic logic [HASH_W-1:0] colour_hash(input logic [7:0] r,
                                                     input logic [7:0] g,
                                                     input logic [7:0] b);
      logic [7:0] sum;
      sum = (r * 8'd3) + (g * 8'd5) + (b * 8'd7);
      return sum[HASH_W-1:0];
   endfunction

endpackage

// ----- hdl/qoi_enc_ram.sv -----
// ---------------------------------------------------------------------------
// QOI encoder generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module qoi_enc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/qoi_enc_csr.sv -----
// ---------------------------------------------------------------------------
// QOI encoder configuration registers
// APB-style access to the image width and height written into the header.
// ---------------------------------------------------------------------------
module qoi_enc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [qoi_enc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [qoi_enc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [qoi_enc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready,
   output logic [31:0]                        image_width,
   output logic [31:0]                        image_height
);
   import qoi_enc_pkg::*;

   logic [31:0] width_ff;
   logic [31:0] width_in;
   logic [31:0] height_ff;
   logic [31:0] height_in;
   logic        wr_transfer;
   logic        reg_sel;

   assign pready      = 1'b1;
   assign wr_transfer = psel && penable && pwrite && pready;
   assign reg_sel     = paddr[2];

   // Register write decode.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_transfer) begin
         case (reg_sel)
            REG_WIDTH:  width_in  = pwdata;
            REG_HEIGHT: height_in = pwdata;
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Read data.
   always_comb begin
      case (reg_sel)
         REG_WIDTH:  prdata = width_ff;
         REG_HEIGHT: prdata = height_ff;
         default:    prdata = '0;
      endcase
   end

   assign image_width  = width_ff;
   assign image_height = height_ff;

endmodule

// ----- hdl/qoi_enc_core.sv -----
// ---------------------------------------------------------------------------
// QOI encoder pixel stage
// Holds one pixel, chooses its op against the previous pixel, the colour
// table and the pending run, and hands the bytes it causes to the serialiser.
// ---------------------------------------------------------------------------
module qoi_enc_core #(
   parameter int MAX_RUN = qoi_enc_pkg::MAX_RUN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   input  logic                  req_final_pixel,
   output logic                  desc_valid,
   output qoi_enc_pkg::desc_type desc,
   input  logic                  desc_ready
);
   import qoi_enc_pkg::*;

   // Input register.
   logic                   a_valid_ff;
   logic                   a_valid_in;
   logic [COLOUR_W-1:0]    px_ff;
   logic [HASH_W-1:0]      hash_ff;
   logic                   fin_ff;
   logic                   fwd_hit_ff;
   logic [COLOUR_W-1:0]    fwd_data_ff;

   // Encoder state.
   logic [COLOUR_W-1:0]    prev_ff;
   logic [COLOUR_W-1:0]    prev_in;
   logic [RUN_W-1:0]       run_ff;
   logic [RUN_W-1:0]       run_in;
   logic                   first_ff;
   logic                   first_in;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] valid_in;

   logic                   req_fire;
   logic                   a_fire;
   logic [HASH_W-1:0]      hash_req;
   logic [COLOUR_W-1:0]    rd_data;
   logic [COLOUR_W-1:0]    entry;
   logic                   table_hit;
   logic                   same_px;
   logic [RUN_W-1:0]       run_inc;
   logic                   run_full;
   logic                   tbl_wr_en;
   logic                   desc_empty;
   desc_type               desc_cur;

   logic [7:0]             px_r;
   logic [7:0]             px_g;
   logic [7:0]             px_b;
   logic signed [8:0]      dr;
   logic signed [8:0]      dg;
   logic signed [8:0]      db;
   logic signed [9:0]      rg;
   logic signed [9:0]      bg;
   logic                   small_diff;
   logic                   luma_diff;

   // Handshake: the held pixel leaves when its bytes can be handed on.
   assign a_fire    = a_valid_ff && (desc_empty || desc_ready);
   assign req_stall = a_valid_ff && !a_fire;
   assign req_fire  = req_valid && !req_stall;
   assign hash_req  = colour_hash(req_red, req_green, req_blue);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_fire) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   // Pixel payload, plus forwarding of a table write made in the same cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff       <= {req_red, req_green, req_blue};
         hash_ff     <= hash_req;
         fin_ff      <= req_final_pixel;
         fwd_hit_ff  <= tbl_wr_en && !fin_ff && (hash_ff == hash_req);
         fwd_data_ff <= px_ff;
      end
   end

   // Colour table storage.
   qoi_enc_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (hash_ff),
      .wr_data (px_ff),
      .rd_en   (req_fire),
      .rd_addr (hash_req),
      .rd_data (rd_data)
   );

   // Table lookup: an entry never written since the stream began reads zero.
   assign entry     = !valid_ff[hash_ff] ? '0 : (fwd_hit_ff ? fwd_data_ff : rd_data);
   assign table_hit = (entry == px_ff);
   assign same_px   = (px_ff == prev_ff);
   assign run_inc   = run_ff + RUN_W'(1);
   assign run_full  = (run_inc >= RUN_W'(MAX_RUN));

   // Plain differences against the previous pixel.
   assign px_r = px_ff[23:16];
   assign px_g = px_ff[15:8];
   assign px_b = px_ff[7:0];
   assign dr   = $signed({1'b0, px_r}) - $signed({1'b0, prev_ff[23:16]});
   assign dg   = $signed({1'b0, px_g}) - $signed({1'b0, prev_ff[15:8]});
   assign db   = $signed({1'b0, px_b}) - $signed({1'b0, prev_ff[7:0]});
   assign rg   = $signed({dr[8], dr}) - $signed({dg[8], dg});
   assign bg   = $signed({db[8], db}) - $signed({dg[8], dg});

   assign small_diff = (dr >= -9'sd2) && (dr <= 9'sd1) && (dg >= -9'sd2) && (dg <= 9'sd1)
                       && (db >= -9'sd2) && (db <= 9'sd1);
   assign luma_diff  = (dg >= -9'sd32) && (dg <= 9'sd31) && (rg >= -10'sd8)
                       && (rg <= 10'sd7) && (bg >= -10'sd8) && (bg <= 10'sd7);

   // Table writes: first pixel, and every differing pixel that missed.
   assign tbl_wr_en = a_fire && (first_ff || (!same_px && !table_hit));

   // Bytes caused by the held pixel.
   always_comb begin
      desc_cur          = '0;
      desc_cur.has_end  = fin_ff;
      if (first_ff) begin
         desc_cur.has_hdr     = 1'b1;
         desc_cur.op_len      = 3'd4;
         desc_cur.op_bytes[0] = OP_RGB;
         desc_cur.op_bytes[1] = px_r;
         desc_cur.op_bytes[2] = px_g;
         desc_cur.op_bytes[3] = px_b;
      end else if (same_px) begin
         // The run is sent as it stands with this pixel counted in.
         desc_cur.has_run  = run_full || fin_ff;
         desc_cur.run_byte = {OP_RUN_TAG, run_ff};
      end else begin
         desc_cur.has_run  = (run_ff != '0);
         desc_cur.run_byte = {OP_RUN_TAG, run_ff - RUN_W'(1)};
         if (table_hit) begin
            desc_cur.op_len      = 3'd1;
            desc_cur.op_bytes[0] = {2'b00, hash_ff};
         end else if (small_diff) begin
            desc_cur.op_len      = 3'd1;
            desc_cur.op_bytes[0] = {OP_DIFF_TAG, dr[1:0] ^ 2'b10, dg[1:0] ^ 2'b10,
                                    db[1:0] ^ 2'b10};
         end else if (luma_diff) begin
            desc_cur.op_len      = 3'd2;
            desc_cur.op_bytes[0] = {OP_LUMA_TAG, dg[5:0] ^ 6'b10_0000};
            desc_cur.op_bytes[1] = {rg[3:0] ^ 4'b1000, bg[3:0] ^ 4'b1000};
         end else begin
            desc_cur.op_len      = 3'd4;
            desc_cur.op_bytes[0] = OP_RGB;
            desc_cur.op_bytes[1] = px_r;
            desc_cur.op_bytes[2] = px_g;
            desc_cur.op_bytes[3] = px_b;
         end
      end
   end

   assign desc_empty = !desc_cur.has_hdr && !desc_cur.has_run && (desc_cur.op_len == '0)
                       && !desc_cur.has_end;
   assign desc_valid = a_valid_ff && !desc_empty;
   assign desc       = desc_cur;

   // State update when the held pixel leaves.
   always_comb begin
      prev_in  = prev_ff;
      run_in   = run_ff;
      first_in = first_ff;
      valid_in = valid_ff;
      if (a_fire) begin
         if (fin_ff) begin
            prev_in  = '0;
            run_in   = '0;
            first_in = 1'b1;
            valid_in = '0;
         end else if (first_ff) begin
            prev_in           = px_ff;
            first_in          = 1'b0;
            valid_in[hash_ff] = 1'b1;
         end else if (same_px) begin
            run_in = run_full ? '0 : run_inc;
         end else begin
            prev_in = px_ff;
            run_in  = '0;
            // An entry is marked only once the table holds it; a hit on an
            // unwritten entry leaves it reading zero.
            if (!table_hit) begin
               valid_in[hash_ff] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         run_ff   <= '0;
         first_ff <= 1'b1;
         valid_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         run_ff   <= run_in;
         first_ff <= first_in;
         valid_ff <= valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A final pixel leaves the encoder ready for a new stream.
   a_final_clears : assert property (@(posedge clock) disable iff (reset)
      a_fire && fin_ff |=> first_ff && (run_ff == '0) && (valid_ff == '0))
      else $error("stream state not cleared after final pixel");

   // A pending run never reaches the flush length.
   a_run_bound : assert property (@(posedge clock) disable iff (reset)
      run_ff < RUN_W'(MAX_RUN))
      else $error("pending run reached its limit");

   // The header is always followed by a raw colour op.
   a_hdr_raw : assert property (@(posedge clock) disable iff (reset)
      desc_valid && desc.has_hdr |-> (desc.op_len == 3'd4) && (desc.op_bytes[0] == OP_RGB))
      else $error("first pixel not coded raw");
`endif

endmodule

// ----- hdl/qoi_enc_ser.sv -----
// ---------------------------------------------------------------------------
// QOI encoder byte serialiser
// Sends the bytes of one pixel in stream order, one per transfer, and takes
// the next pixel's bytes in the cycle its last byte goes out.
// ---------------------------------------------------------------------------
module qoi_enc_ser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  desc_valid,
   input  qoi_enc_pkg::desc_type desc,
   output logic                  desc_ready,
   input  logic [31:0]           image_width,
   input  logic [31:0]           image_height,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_code_byte,
   output logic                  rsp_last_of_item,
   output logic                  rsp_stream_done
);
   import qoi_enc_pkg::*;

   logic             busy_ff;
   logic             busy_in;
   seg_type          seg_ff;
   seg_type          seg_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   desc_type         desc_ff;
   desc_type         desc_in;

   logic [IDX_W-1:0] seg_len;
   logic             seg_last;
   seg_type          seg_next;
   logic             last_byte;
   logic             out_fire;
   logic             load;
   logic [7:0]       hdr_bytes [14];

   // Segment that follows cur in the byte list of d; SEG_IDLE when none does.
   function automatic seg_type next_seg(input seg_type cur, input desc_type d);
      logic take_hdr;
      logic take_run;
      logic take_op;
      logic take_end;
      take_hdr = d.has_hdr && (cur == SEG_IDLE);
      take_run = d.has_run && ((cur == SEG_IDLE) || (cur == SEG_HDR));
      take_op  = (d.op_len != '0) && ((cur == SEG_IDLE) || (cur == SEG_HDR)
                                      || (cur == SEG_RUN));
      take_end = d.has_end && (cur != SEG_END);
      if (take_hdr) begin
         return SEG_HDR;
      end else if (take_run) begin
         return SEG_RUN;
      end else if (take_op) begin
         return SEG_OP;
      end else if (take_end) begin
         return SEG_END;
      end else begin
         return SEG_IDLE;
      end
   endfunction

   // Length of the segment being sent.
   always_comb begin
      case (seg_ff)
         SEG_HDR: seg_len = HDR_LEN;
         SEG_RUN: seg_len = RUN_LEN;
         SEG_OP:  seg_len = {1'b0, desc_ff.op_len};
         SEG_END: seg_len = END_LEN;
         default: seg_len = RUN_LEN;
      endcase
   end

   assign seg_last   = (idx_ff == seg_len - IDX_W'(1));
   assign seg_next   = next_seg(seg_ff, desc_ff);
   assign last_byte  = seg_last && (seg_next == SEG_IDLE);
   assign out_fire   = busy_ff && !rsp_stall;
   assign desc_ready = !busy_ff || (out_fire && last_byte);
   assign load       = desc_valid && desc_ready;

   // Next state.
   always_comb begin
      busy_in = busy_ff;
      seg_in  = seg_ff;
      idx_in  = idx_ff;
      desc_in = desc_ff;
      if (load) begin
         busy_in = 1'b1;
         seg_in  = next_seg(SEG_IDLE, desc);
         idx_in  = '0;
         desc_in = desc;
      end else if (out_fire) begin
         if (last_byte) begin
            busy_in = 1'b0;
            seg_in  = SEG_IDLE;
         end else if (seg_last) begin
            seg_in = seg_next;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seg_ff  <= SEG_IDLE;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         seg_ff  <= seg_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   // Header bytes: magic, width and height big-endian, channels, colour space.
   always_comb begin
      hdr_bytes[0]  = HDR_MAGIC[31:24];
      hdr_bytes[1]  = HDR_MAGIC[23:16];
      hdr_bytes[2]  = HDR_MAGIC[15:8];
      hdr_bytes[3]  = HDR_MAGIC[7:0];
      hdr_bytes[4]  = image_width[31:24];
      hdr_bytes[5]  = image_width[23:16];
      hdr_bytes[6]  = image_width[15:8];
      hdr_bytes[7]  = image_width[7:0];
      hdr_bytes[8]  = image_height[31:24];
      hdr_bytes[9]  = image_height[23:16];
      hdr_bytes[10] = image_height[15:8];
      hdr_bytes[11] = image_height[7:0];
      hdr_bytes[12] = HDR_CHANNELS;
      hdr_bytes[13] = HDR_COLOURSPACE;
   end

   // Outputs.
   always_comb begin
      rsp_valid        = busy_ff;
      rsp_last_of_item = last_byte;
      rsp_stream_done  = 1'b0;
      case (seg_ff)
         SEG_HDR: rsp_code_byte = hdr_bytes[idx_ff];
         SEG_RUN: rsp_code_byte = desc_ff.run_byte;
         SEG_OP:  rsp_code_byte = desc_ff.op_bytes[idx_ff[1:0]];
         SEG_END: begin
            rsp_code_byte   = seg_last ? END_LAST : END_PAD;
            rsp_stream_done = seg_last;
         end
         default: rsp_code_byte = END_PAD;
      endcase
   end

`ifndef NO_ASSERTIONS
   // While busy there is always a segment to send.
   a_busy_seg : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (seg_ff != SEG_IDLE))
      else $error("serialiser busy without a segment");

   // The end marker closes the bytes of its pixel.
   a_done_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_last_of_item)
      else $error("end marker is not the last byte of its pixel");
`endif

endmodule

// ----- hdl/qoi_rgb_image_encoder.sv -----
// ---------------------------------------------------------------------------
// QOI RGB image encoder
// Turns a stream of RGB pixels into a QOI-style byte stream.
// ---------------------------------------------------------------------------
// Usage: pixels arrive on the req_ channel, one per transfer; req_final_pixel
// marks the last pixel of an image. Encoded bytes leave on the rsp_ channel,
// one per transfer, with rsp_last_of_item on the last byte caused by a pixel
// and rsp_stream_done on the closing end-marker byte. Width and height for
// the header are written over the APB port before the first pixel.
// A pixel passes the core's input register, then the serialiser shows its
// first byte. Throughput: pixels causing one byte or none flow at one per
// cycle while rsp_stall is low; a pixel that causes k bytes holds the input
// until its last byte goes out, set by the single byte-wide output port (the
// first pixel of an image causes 18 bytes, 26 when it is also the last).
// Reset clears the registers, the previous pixel, the pending run and the
// colour table, and the next pixel starts a new stream with its header.
// A stall on rsp_ holds the byte shown; the input register then fills and
// req_stall rises until the serialiser moves on.
// ---------------------------------------------------------------------------
module qoi_rgb_image_encoder #(
   parameter int MAX_RUN = qoi_enc_pkg::MAX_RUN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_red,
   input  logic [7:0]                         req_green,
   input  logic [7:0]                         req_blue,
   input  logic                               req_final_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_code_byte,
   output logic                               rsp_last_of_item,
   output logic                               rsp_stream_done,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [qoi_enc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [qoi_enc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [qoi_enc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready
);
   import qoi_enc_pkg::*;

   logic [31:0] image_width;
   logic [31:0] image_height;
   logic        desc_valid;
   logic        desc_ready;
   desc_type    desc;

   // Configuration registers.
   qoi_enc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .image_width  (image_width),
      .image_height (image_height)
   );

   // Pixel stage.
   qoi_enc_core #(
      .MAX_RUN (MAX_RUN)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_final_pixel (req_final_pixel),
      .desc_valid      (desc_valid),
      .desc            (desc),
      .desc_ready      (desc_ready)
   );

   // Byte serialiser.
   qoi_enc_ser u_ser (
      .clock            (clock),
      .reset            (reset),
      .desc_valid       (desc_valid),
      .desc             (desc),
      .desc_ready       (desc_ready),
      .image_width      (image_width),
      .image_height     (image_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_stream_done  (rsp_stream_done)
   );

endmodule
